@@ hdl/mutex_condvar_wait_queue_engine_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MUTEX_CONDVAR_WAIT_QUEUE_ENGINE_DEFINES_SVH
`define MUTEX_CONDVAR_WAIT_QUEUE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCWQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcwq: %s failed", "label");

// Next-cycle implication, sampled on clk, off during reset.
`define MCWQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcwq: %s failed", "label");

`endif

@@ hdl/mcwq_pkg.sv @@
package mcwq_pkg;

  localparam int MAX_TASKS   = 8;
  localparam int QUEUE_DEPTH = 8;

  localparam int TASK_W = 3;
  localparam int REQ_W  = 3;
  localparam int KIND_W = 3;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOCK      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNLOCK    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COND_WAIT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SIGNAL    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BROADCAST = 3'd4;

  // Event codes
  localparam logic [KIND_W-1:0] EV_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] EV_BLOCKED  = 3'd1;
  localparam logic [KIND_W-1:0] EV_WOKEN    = 3'd2;
  localparam logic [KIND_W-1:0] EV_DONE     = 3'd3;
  localparam logic [KIND_W-1:0] EV_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TASK_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [TASK_W-1:0] event_task;
    logic              mutex_held;
    logic              last;
  } out_item_t;

  // Per-queue command from the sequencer
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TASK_W-1:0] push_data;
  } fifo_ctl_t;

endpackage

@@ hdl/mcwq_fifo.sv @@
// Task queue: circular buffer in a synchronous RAM, registered read data.
module mcwq_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcwq_pkg::fifo_ctl_t             ctl,
  output logic [mcwq_pkg::TASK_W-1:0]     rd_data,
  output logic [mcwq_pkg::CNT_W-1:0]      count
);

  localparam logic [mcwq_pkg::QIDX_W-1:0] IDX_LAST =
    mcwq_pkg::QIDX_W'(mcwq_pkg::QUEUE_DEPTH - 1);

  logic [mcwq_pkg::TASK_W-1:0] mem [mcwq_pkg::QUEUE_DEPTH];
  logic [mcwq_pkg::TASK_W-1:0] rd_data_r;
  logic [mcwq_pkg::QIDX_W-1:0] head_r, head_nxt;
  logic [mcwq_pkg::QIDX_W-1:0] tail_r, tail_nxt;
  logic [mcwq_pkg::CNT_W-1:0]  count_r, count_nxt;

  // RAM port: write at tail, read at head; read data holds between pops
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.push_data;
    end
    if (ctl.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  // Pointer and fill count update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push) begin
      tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_nxt + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt  = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

@@ hdl/mutex_condvar_wait_queue_engine.sv @@
// Mutex with one condition variable and two FIFO wait queues.
// Input channel in_valid/in_stall/in_data carries one request (lock, unlock,
// condition wait, signal, broadcast) and a task number. Output channel
// out_valid/out_stall/out_data carries the events of that request; the last
// event of a request has last set, and mutex_held is the lock state after it.
// Requests that touch no queue entry (grant, block, overflow, done) load
// their event into the output register at the transfer. Requests that wake
// tasks pop the queue RAM first, into its read register, then the output
// register; further wakes of a broadcast follow one per cycle unless stalled.
// Throughput: one request per cycle without wakes while out_stall is low; the
// one-at-a-time sequencer takes no new request until the last wake is loaded.
// A new request is taken once the previous one has queued all its events
// and the output register is free or being emptied.
// Stall: while out_stall is high the output register holds its event and the
// sequencer waits; in_stall rises in turn.
// Reset (rst_n low, synchronous) frees the mutex, empties both queues and
// drops out_valid; queue RAM contents are not cleared.
module mutex_condvar_wait_queue_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcwq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcwq_pkg::out_item_t out_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  localparam logic Q_MUTEX = 1'b0;
  localparam logic Q_COND  = 1'b1;

  localparam logic [mcwq_pkg::CNT_W-1:0] CNT_FULL =
    mcwq_pkg::CNT_W'(mcwq_pkg::QUEUE_DEPTH);

  logic                         state_r, state_nxt;
  logic                         locked_r, locked_nxt;
  logic                         qsel_r, qsel_nxt;
  logic [mcwq_pkg::CNT_W-1:0]   pops_r, pops_nxt;
  logic                         out_valid_r;
  mcwq_pkg::out_item_t          out_r;

  mcwq_pkg::fifo_ctl_t          mq_ctl, cq_ctl;
  logic [mcwq_pkg::TASK_W-1:0]  mq_rd, cq_rd;
  logic [mcwq_pkg::CNT_W-1:0]   mq_cnt, cq_cnt;

  logic                         out_free;
  logic                         in_xfer;
  logic                         load;
  mcwq_pkg::out_item_t          load_item;
  logic [mcwq_pkg::KIND_W-1:0]  ev_kind;
  logic [mcwq_pkg::TASK_W-1:0]  ev_task;
  logic                         ev_last;

  // The two queues never push and pop the same queue in one cycle, and an
  // entry is read only after the cycle that wrote it, so no forwarding.
  mcwq_fifo u_mutex_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mq_ctl),
    .rd_data (mq_rd),
    .count   (mq_cnt)
  );

  mcwq_fifo u_cond_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cq_ctl),
    .rd_data (cq_rd),
    .count   (cq_cnt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_xfer  = in_valid && !in_stall;

  // Request decode and wake sequencer
  always_comb begin
    state_nxt = state_r;
    locked_nxt = locked_r;
    qsel_nxt  = qsel_r;
    pops_nxt  = pops_r;
    mq_ctl    = '0;
    cq_ctl    = '0;
    load      = 1'b0;
    ev_kind   = mcwq_pkg::EV_DONE;
    ev_task   = in_data.task_id;
    ev_last   = 1'b1;
    mq_ctl.push_data = in_data.task_id;
    cq_ctl.push_data = in_data.task_id;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (int'(in_data.task_id) >= mcwq_pkg::MAX_TASKS) begin
            load = 1'b1;
          end else begin
            unique case (in_data.req_type)
              mcwq_pkg::REQ_LOCK: begin
                load = 1'b1;
                if (!locked_r) begin
                  locked_nxt = 1'b1;
                  ev_kind    = mcwq_pkg::EV_GRANTED;
                end else if (mq_cnt < CNT_FULL) begin
                  mq_ctl.push = 1'b1;
                  ev_kind     = mcwq_pkg::EV_BLOCKED;
                end else begin
                  ev_kind = mcwq_pkg::EV_OVERFLOW;
                end
              end
              mcwq_pkg::REQ_UNLOCK: begin
                locked_nxt = 1'b0;
                if (mq_cnt != '0) begin
                  mq_ctl.pop = 1'b1;
                  qsel_nxt   = Q_MUTEX;
                  pops_nxt   = mcwq_pkg::CNT_W'(1);
                  state_nxt  = S_RD;
                end else begin
                  load = 1'b1;
                end
              end
              mcwq_pkg::REQ_COND_WAIT: begin
                load = 1'b1;
                if (cq_cnt < CNT_FULL) begin
                  cq_ctl.push = 1'b1;
                  locked_nxt  = 1'b0;
                  ev_kind     = mcwq_pkg::EV_BLOCKED;
                  if (mq_cnt != '0) begin
                    ev_last    = 1'b0;
                    mq_ctl.pop = 1'b1;
                    qsel_nxt   = Q_MUTEX;
                    pops_nxt   = mcwq_pkg::CNT_W'(1);
                    state_nxt  = S_RD;
                  end
                end else begin
                  ev_kind = mcwq_pkg::EV_OVERFLOW;
                end
              end
              mcwq_pkg::REQ_SIGNAL, mcwq_pkg::REQ_BROADCAST: begin
                if (cq_cnt != '0) begin
                  cq_ctl.pop = 1'b1;
                  qsel_nxt   = Q_COND;
                  pops_nxt   = (in_data.req_type == mcwq_pkg::REQ_SIGNAL) ?
                               mcwq_pkg::CNT_W'(1) : cq_cnt;
                  state_nxt  = S_RD;
                end else begin
                  load = 1'b1;
                end
              end
              default: begin
                load = 1'b1;
              end
            endcase
          end
        end
      end
      S_RD: begin
        // Read data of the last pop is held until the next pop
        if (out_free) begin
          load     = 1'b1;
          ev_kind  = mcwq_pkg::EV_WOKEN;
          ev_task  = (qsel_r == Q_COND) ? cq_rd : mq_rd;
          ev_last  = (pops_r == mcwq_pkg::CNT_W'(1));
          pops_nxt = pops_r - 1'b1;
          if (ev_last) begin
            state_nxt = S_IDLE;
          end else if (qsel_r == Q_COND) begin
            cq_ctl.pop = 1'b1;
          end else begin
            mq_ctl.pop = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    load_item.event_kind = ev_kind;
    load_item.event_task = ev_task;
    load_item.mutex_held = locked_nxt;
    load_item.last       = ev_last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      locked_r    <= 1'b0;
      qsel_r      <= Q_MUTEX;
      pops_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      locked_r <= locked_nxt;
      qsel_r   <= qsel_nxt;
      pops_r   <= pops_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= load_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/mcwq_checker.sv @@
`include "mutex_condvar_wait_queue_engine_defines.svh"

// Port-level checks on the request and result channels.
module mcwq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mcwq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mcwq_pkg::out_item_t out_data
);

  logic in_xfer;
  logic ev_grant;
  logic ev_single;
  assign in_xfer = in_valid && !in_stall && (in_data.req_type == mcwq_pkg::REQ_LOCK);
  assign ev_grant = out_valid && (out_data.event_kind == mcwq_pkg::EV_GRANTED);
  assign ev_single = out_valid && (out_data.event_kind == mcwq_pkg::EV_OVERFLOW ||
                                   out_data.event_kind == mcwq_pkg::EV_DONE);

  // A stalled event stays put
  `MCWQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // A grant leaves the mutex held and ends its request
  `MCWQ_ASSERT_IMP(a_grant, ev_grant, out_data.mutex_held && out_data.last)

  // Overflow and done are always the single event of a request
  `MCWQ_ASSERT_IMP(a_single, ev_single, out_data.last)

  // A lock transfer shows its one event in the next cycle, mutex held
  `MCWQ_ASSERT_NXT(a_lock_event, in_xfer, out_valid && out_data.last && out_data.mutex_held)

endmodule

bind mutex_condvar_wait_queue_engine mcwq_checker u_mcwq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcwq_pkg::*;

  // Request codes outside the defined set; the block answers them with "done".
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  localparam int RANDOM_ITEMS = 443;
  localparam int HOLD_AT      = 150;   // item index where the long output hold starts
  localparam int STEADY_ITEMS = 40;    // back-to-back items offered during the hold
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_AT     = 320;   // item index where the sender waits for all events
  localparam int QUIET_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES  = 8;

  // One row of the directed sequence; typed rows carry the event to expect.
  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [TASK_W-1:0] tid;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] who;
    logic              held;
  } step_t;

  localparam int N_STEPS = 27;
  localparam step_t STEPS [N_STEPS] = '{
    // empty queues right after reset
    '{REQ_UNLOCK,    3'd0, 1'b1, EV_DONE,     3'd0, 1'b0},
    '{REQ_SIGNAL,    3'd7, 1'b1, EV_DONE,     3'd7, 1'b0},
    '{REQ_BROADCAST, 3'd0, 1'b1, EV_DONE,     3'd0, 1'b0},
    // unknown request types
    '{REQ_BAD_LO,    3'd3, 1'b1, EV_DONE,     3'd3, 1'b0},
    '{REQ_BAD_HI,    3'd7, 1'b1, EV_DONE,     3'd7, 1'b0},
    // grant, then the owner blocks on itself
    '{REQ_LOCK,      3'd0, 1'b1, EV_GRANTED,  3'd0, 1'b1},
    '{REQ_LOCK,      3'd0, 1'b1, EV_BLOCKED,  3'd0, 1'b1},
    // fill the mutex queue
    '{REQ_LOCK,      3'd1, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd2, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd3, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd4, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd5, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd6, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd7, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_LOCK,      3'd7, 1'b1, EV_OVERFLOW, 3'd7, 1'b1},
    // unlock by a task that does not own the mutex
    '{REQ_UNLOCK,    3'd5, 1'b0, EV_DONE,     3'd0, 1'b0},
    // fill the condition queue; the last wait finds no mutex waiter
    '{REQ_COND_WAIT, 3'd0, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd1, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd2, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd3, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd4, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd5, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd6, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd7, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_COND_WAIT, 3'd4, 1'b1, EV_OVERFLOW, 3'd4, 1'b0},
    // wake one, then all the rest
    '{REQ_SIGNAL,    3'd2, 1'b0, EV_DONE,     3'd0, 1'b0},
    '{REQ_BROADCAST, 3'd6, 1'b0, EV_DONE,     3'd0, 1'b0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Predictor state
  logic              lock_taken;
  logic [TASK_W-1:0] lock_owner;
  logic [TASK_W-1:0] mutex_waiters [$];
  logic [TASK_W-1:0] cond_waiters [$];
  out_item_t         pending_events [$];

  bit hold_req;      // asks the receiver for one long hold-off
  bit steady;        // sender offers back to back while set
  int burst_left;
  int errors;
  int n_requests;
  int n_events;
  int n_wakes;
  int n_overflows;
  int widest_broadcast;
  out_item_t want;

  mutex_condvar_wait_queue_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Events that one request causes, with the lock state updated as the block does.
  task automatic apply_request(input in_item_t r, output out_item_t evs[$]);
    int fan;
    evs = {};
    fan = 0;
    case (r.req_type)
      REQ_LOCK: begin
        if (!lock_taken) begin
          lock_taken = 1'b1;
          lock_owner = r.task_id;
          evs.push_back('{EV_GRANTED, r.task_id, 1'b0, 1'b0});
        end else if (mutex_waiters.size() < QUEUE_DEPTH) begin
          mutex_waiters.push_back(r.task_id);
          evs.push_back('{EV_BLOCKED, r.task_id, 1'b0, 1'b0});
        end else begin
          evs.push_back('{EV_OVERFLOW, r.task_id, 1'b0, 1'b0});
        end
      end
      REQ_UNLOCK: begin
        lock_taken = 1'b0;
        lock_owner = '0;
        if (mutex_waiters.size() > 0)
          evs.push_back('{EV_WOKEN, mutex_waiters.pop_front(), 1'b0, 1'b0});
        else
          evs.push_back('{EV_DONE, r.task_id, 1'b0, 1'b0});
      end
      REQ_COND_WAIT: begin
        if (cond_waiters.size() >= QUEUE_DEPTH) begin
          evs.push_back('{EV_OVERFLOW, r.task_id, 1'b0, 1'b0});
        end else begin
          cond_waiters.push_back(r.task_id);
          evs.push_back('{EV_BLOCKED, r.task_id, 1'b0, 1'b0});
          lock_taken = 1'b0;
          lock_owner = '0;
          if (mutex_waiters.size() > 0)
            evs.push_back('{EV_WOKEN, mutex_waiters.pop_front(), 1'b0, 1'b0});
        end
      end
      REQ_SIGNAL: begin
        if (cond_waiters.size() > 0)
          evs.push_back('{EV_WOKEN, cond_waiters.pop_front(), 1'b0, 1'b0});
        else
          evs.push_back('{EV_DONE, r.task_id, 1'b0, 1'b0});
      end
      REQ_BROADCAST: begin
        while (cond_waiters.size() > 0 && evs.size() < QUEUE_DEPTH) begin
          evs.push_back('{EV_WOKEN, cond_waiters.pop_front(), 1'b0, 1'b0});
          fan++;
        end
        if (evs.size() == 0)
          evs.push_back('{EV_DONE, r.task_id, 1'b0, 1'b0});
        if (fan > widest_broadcast)
          widest_broadcast = fan;
      end
      default: evs.push_back('{EV_DONE, r.task_id, 1'b0, 1'b0});
    endcase
    foreach (evs[k]) begin
      evs[k].mutex_held = lock_taken;
      evs[k].last       = (k == evs.size() - 1);
      if (evs[k].event_kind == EV_WOKEN)
        n_wakes++;
      if (evs[k].event_kind == EV_OVERFLOW)
        n_overflows++;
    end
  endtask

  // Offer one request from a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input in_item_t r, input logic typed, input out_item_t typed_ev);
    out_item_t evs[$];
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    apply_request(r, evs);
    if (typed) begin
      typed_ev.last = 1'b1;
      pending_events.push_back(typed_ev);
    end else begin
      foreach (evs[k])
        pending_events.push_back(evs[k]);
    end
    n_requests++;
    @(negedge clk);
  endtask

  // Sender pacing: bursts of random length separated by random gaps, no gaps while steady is set.
  task automatic pace();
    if (steady || burst_left > 0) begin
      if (burst_left > 0)
        burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 11);
    end
  endtask

  function automatic void check_field(input string name, input logic [2:0] exp_v,
                                      input logic [2:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest pending event
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, got kind %0d task %0d held %0d last %0d", $time,
                 out_data.event_kind, out_data.event_task, out_data.mutex_held, out_data.last);
        errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.event_kind, out_data.event_kind);
        check_field("event_task", want.event_task, out_data.event_task);
        check_field("mutex_held", {2'b00, want.mutex_held}, {2'b00, out_data.mutex_held});
        check_field("last",       {2'b00, want.last},       {2'b00, out_data.last});
      end
      n_events++;
    end
  end

  // Receiver: stall pattern switches among three random modes; one long hold on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Watchdog: too long without any transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d events still pending", $time,
             QUIET_LIMIT, pending_events.size());
    $display("** mutex_condvar_wait_queue_engine: FAILED **");
    $finish;
  end

  // Stimulus: directed sequence, then random requests
  initial begin : stimulus
    in_item_t  req;
    out_item_t ev;
    int        pick;
    bit        fill_mode;
    lock_taken = 1'b0;
    lock_owner = '0;
    fill_mode  = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_STEPS; i++) begin
      req.req_type  = STEPS[i].op;
      req.task_id   = STEPS[i].tid;
      ev.event_kind = STEPS[i].kind;
      ev.event_task = STEPS[i].who;
      ev.mutex_held = STEPS[i].held;
      ev.last       = 1'b0;
      offer(req, STEPS[i].typed, ev);
      pace();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        hold_req = 1'b1;
        steady   = 1'b1;
      end
      if (n == HOLD_AT + STEADY_ITEMS)
        steady = 1'b0;
      // sender pause until every pending event has come out
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        do
          @(negedge clk);
        while (pending_events.size() != 0);
      end
      // pick at random between phases that fill the queues and phases that drain them
      if (n % 8 == 0)
        fill_mode = ($urandom_range(0, 1) == 1);
      pick = $urandom_range(0, 99);
      if (fill_mode) begin
        if (pick < 45)      req.req_type = REQ_LOCK;
        else if (pick < 75) req.req_type = REQ_COND_WAIT;
        else if (pick < 85) req.req_type = REQ_UNLOCK;
        else if (pick < 90) req.req_type = REQ_SIGNAL;
        else if (pick < 95) req.req_type = REQ_BROADCAST;
        else                req.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      end else begin
        if (pick < 20)      req.req_type = REQ_LOCK;
        else if (pick < 30) req.req_type = REQ_COND_WAIT;
        else if (pick < 60) req.req_type = REQ_UNLOCK;
        else if (pick < 80) req.req_type = REQ_SIGNAL;
        else if (pick < 95) req.req_type = REQ_BROADCAST;
        else                req.req_type = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      end
      req.task_id = TASK_W'($urandom_range(0, MAX_TASKS - 1));
      offer(req, 1'b0, '0);
      pace();
    end

    in_valid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d directed) and %0d events: %0d wakes, %0d overflows,",
             n_requests, N_STEPS, n_events, n_wakes, n_overflows);
    $display("widest broadcast %0d, one long output hold-off and one full drain pause.",
             widest_broadcast);
    if (errors == 0) begin
      $display("** mutex_condvar_wait_queue_engine: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** mutex_condvar_wait_queue_engine: FAILED **");
    end
    $finish;
  end

endmodule
